FILE: hw/rtl/cell_luma_block_averager_core_assert.svh
`ifndef CELL_LUMA_BLOCK_AVERAGER_CORE_ASSERT_SVH
`define CELL_LUMA_BLOCK_AVERAGER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLBA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/clba_pkg.sv
package clba_pkg;

  localparam int unsigned REG_W     = 12;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned PX_W      = 2 * REG_W;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LUMA_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 12'd1280;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 12'd720;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              frame_start;
  } clba_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_col;
    logic [IDX_W-1:0]  cell_row;
    logic [LUMA_W-1:0] mean_luma;
  } clba_out_t;

  // frame and cell geometry from the configuration unit
  typedef struct packed {
    logic             ready;
    logic [REG_W-1:0] frame_w;
    logic [REG_W-1:0] frame_h;
    logic [REG_W-1:0] cell_w;
    logic [REG_W-1:0] cell_h;
    logic [PX_W-1:0]  cell_px;
  } clba_geom_t;

  typedef struct packed {
    logic              valid;
    logic              clear;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [LUMA_W-1:0] luma;
    logic              load;
    logic              emit;
  } clba_acc_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } clba_div_req_t;

  typedef enum logic [1:0] {
    CFG_CALC,
    CFG_MUL,
    CFG_DONE
  } clba_cfg_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } clba_div_state_e;

endpackage

FILE: hw/rtl/cell_luma_block_averager_core.sv
// Block-average downsampler for the luma plane of a camera frame.
// Input channel (in_valid_i/in_ready_o/in_data_i): one luma byte per item in
// raster order; frame_start on the first pixel of a frame restarts the grid.
// Output channel (out_valid_o/out_ready_i/out_data_o): one item per finished
// cell with its grid column, grid row and truncated mean luma.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): index 0
// is the frame width, index 1 the frame height; always ready.
// Throughput: one pixel per cycle. A pixel that closes a cell is held off
// while the divider is still busy with the previous cell; the divider
// produces one quotient bit per cycle over the 20-bit sum.
// A cell result is offered once its last pixel has passed the column sum
// read-modify-write register, the divider load and the 20 divider steps.
// Reset and every register write recompute the cell size by reciprocal
// multiplication and then the cell area: the input is not ready until both
// are registered.
// A stalled receiver keeps the result in the divider's output register;
// pixels keep flowing until the next cell-closing pixel.
`include "cell_luma_block_averager_core_assert.svh"

module cell_luma_block_averager_core #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 36
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  clba_pkg::clba_in_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output clba_pkg::clba_out_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [clba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [clba_pkg::REG_W-1:0]         cfg_data_i
);
  import clba_pkg::*;

  localparam int unsigned GC_W = $clog2(GRID_COLS + 1);
  localparam int unsigned GR_W = $clog2(GRID_ROWS + 1);
  localparam logic [GC_W-1:0] COL_LIMIT = GC_W'(GRID_COLS);
  localparam logic [GR_W-1:0] ROW_LIMIT = GR_W'(GRID_ROWS);

  clba_geom_t    geom;
  clba_acc_req_t acc_req;
  clba_div_req_t div_req;
  logic          div_busy;
  logic          accept;

  logic [REG_W-1:0] pixel_x_q, pixel_x_d, pixel_y_q, pixel_y_d;
  logic [REG_W-1:0] x_in_cell_q, x_in_cell_d, y_in_cell_q, y_in_cell_d;
  logic [GC_W-1:0]  grid_col_q, grid_col_d;
  logic [GR_W-1:0]  grid_row_q, grid_row_d;

  logic [REG_W-1:0] px, py, xc, yc;
  logic [GC_W-1:0]  gc;
  logic [GR_W-1:0]  gr;
  logic [REG_W:0]   px_inc, py_inc, xc_inc, yc_inc;
  logic             active, load0, emit0;

  // frame start puts the pixel at the origin before it is used
  always_comb begin
    px = in_data_i.frame_start ? '0 : pixel_x_q;
    py = in_data_i.frame_start ? '0 : pixel_y_q;
    xc = in_data_i.frame_start ? '0 : x_in_cell_q;
    yc = in_data_i.frame_start ? '0 : y_in_cell_q;
    gc = in_data_i.frame_start ? '0 : grid_col_q;
    gr = in_data_i.frame_start ? '0 : grid_row_q;

    active = (geom.cell_w != '0) && (geom.cell_h != '0) &&
             (gc < COL_LIMIT) && (gr < ROW_LIMIT);
    load0  = (xc == '0) && (yc == '0);
    emit0  = active && (xc == geom.cell_w - 1'b1) && (yc == geom.cell_h - 1'b1);

    px_inc = {1'b0, px} + 1'b1;
    py_inc = {1'b0, py} + 1'b1;
    xc_inc = {1'b0, xc} + 1'b1;
    yc_inc = {1'b0, yc} + 1'b1;

    pixel_x_d   = px_inc[REG_W-1:0];
    pixel_y_d   = py;
    x_in_cell_d = xc_inc[REG_W-1:0];
    y_in_cell_d = yc;
    grid_col_d  = gc;
    grid_row_d  = gr;

    if (xc_inc >= {1'b0, geom.cell_w}) begin
      x_in_cell_d = '0;
      if (gc < COL_LIMIT) begin
        grid_col_d = gc + 1'b1;
      end
    end
    // end of line
    if (px_inc >= {1'b0, geom.frame_w}) begin
      pixel_x_d   = '0;
      x_in_cell_d = '0;
      grid_col_d  = '0;
      pixel_y_d   = py_inc[REG_W-1:0];
      y_in_cell_d = yc_inc[REG_W-1:0];
      if (yc_inc >= {1'b0, geom.cell_h}) begin
        y_in_cell_d = '0;
        if (gr < ROW_LIMIT) begin
          grid_row_d = gr + 1'b1;
        end
      end
      // end of frame wraps to the origin
      if (py_inc >= {1'b0, geom.frame_h}) begin
        pixel_y_d   = '0;
        y_in_cell_d = '0;
        grid_row_d  = '0;
      end
    end
  end

  assign in_ready_o  = geom.ready && !(emit0 && (div_busy || div_req.valid));
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q   <= '0;
      pixel_y_q   <= '0;
      x_in_cell_q <= '0;
      y_in_cell_q <= '0;
      grid_col_q  <= '0;
      grid_row_q  <= '0;
    end else if (accept) begin
      pixel_x_q   <= pixel_x_d;
      pixel_y_q   <= pixel_y_d;
      x_in_cell_q <= x_in_cell_d;
      y_in_cell_q <= y_in_cell_d;
      grid_col_q  <= grid_col_d;
      grid_row_q  <= grid_row_d;
    end
  end

  assign acc_req.valid = accept && active;
  assign acc_req.clear = accept && in_data_i.frame_start;
  assign acc_req.col   = IDX_W'(gc);
  assign acc_req.row   = IDX_W'(gr);
  assign acc_req.luma  = in_data_i.luma;
  assign acc_req.load  = load0;
  assign acc_req.emit  = emit0;

  clba_cfg #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  clba_acc #(
    .GRID_COLS(GRID_COLS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (acc_req),
    .div_req_o(div_req)
  );

  clba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .divisor_i  (geom.cell_px),
    .busy_o     (div_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `CLBA_ASSERT_IMP(a_emit_div_free, accept && emit0, !div_busy && !div_req.valid, "cell closed while divider engaged")
  `CLBA_ASSERT_IMP(a_div_start_idle, div_req.valid, !div_busy, "divider started while busy")
  `CLBA_ASSERT_NXT(a_cfg_recalc, cfg_valid_i, !in_ready_o, "input ready during cell size recalculation")

endmodule

FILE: hw/rtl/clba_cfg.sv
module clba_cfg #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 36
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [clba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [clba_pkg::REG_W-1:0]         cfg_data_i,
  output clba_pkg::clba_geom_t               geom_o
);
  import clba_pkg::*;

  // cell size by reciprocal multiplication, exact over the full register range
  localparam int unsigned SH_W   = REG_W + $clog2(GRID_COLS);
  localparam int unsigned SH_H   = REG_W + $clog2(GRID_ROWS);
  localparam int unsigned RCP_W  = REG_W + 2;
  localparam int unsigned PROD_W = REG_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_COLS =
    RCP_W'(((1 << SH_W) + GRID_COLS - 1) / GRID_COLS);
  localparam logic [RCP_W-1:0] RCP_ROWS =
    RCP_W'(((1 << SH_H) + GRID_ROWS - 1) / GRID_ROWS);

  clba_cfg_state_e   state_q, state_d;
  logic [REG_W-1:0]  fw_q, fw_d, fh_q, fh_d;
  logic [REG_W-1:0]  cw_q, ch_q;
  logic [PX_W-1:0]   px_q;
  logic [PROD_W-1:0] prod_w, prod_h;

  assign prod_w = PROD_W'(fw_q) * PROD_W'(RCP_COLS);
  assign prod_h = PROD_W'(fh_q) * PROD_W'(RCP_ROWS);

  always_comb begin
    state_d = state_q;
    fw_d    = fw_q;
    fh_d    = fh_q;
    case (state_q)
      CFG_CALC: begin
        state_d = CFG_MUL;
      end
      CFG_MUL: begin
        state_d = CFG_DONE;
      end
      CFG_DONE: begin
        state_d = CFG_DONE;
      end
      default: begin
        state_d = CFG_CALC;
      end
    endcase
    // a register write restarts the cell size calculation
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        fw_d = cfg_data_i;
      end else if (cfg_index_i == REG_FRAME_HEIGHT) begin
        fh_d = cfg_data_i;
      end
      state_d = CFG_CALC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_CALC;
      fw_q    <= FRAME_WIDTH_RST;
      fh_q    <= FRAME_HEIGHT_RST;
    end else begin
      state_q <= state_d;
      fw_q    <= fw_d;
      fh_q    <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CFG_CALC) begin
      cw_q <= REG_W'(prod_w >> SH_W);
      ch_q <= REG_W'(prod_h >> SH_H);
    end
    if (state_q == CFG_MUL) begin
      px_q <= PX_W'(cw_q) * PX_W'(ch_q);
    end
  end

  assign geom_o.ready   = (state_q == CFG_DONE);
  assign geom_o.frame_w = fw_q;
  assign geom_o.frame_h = fh_q;
  assign geom_o.cell_w  = cw_q;
  assign geom_o.cell_h  = ch_q;
  assign geom_o.cell_px = px_q;

endmodule

FILE: hw/rtl/clba_acc.sv
module clba_acc #(
  parameter int unsigned GRID_COLS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  clba_pkg::clba_acc_req_t req_i,
  output clba_pkg::clba_div_req_t div_req_o
);
  import clba_pkg::*;

  localparam int unsigned AW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  logic [SUM_W-1:0]  mem_q [GRID_COLS];
  logic [SUM_W-1:0]  rdata_q;
  logic [GRID_COLS-1:0] vld_q;

  logic              s1_valid_q;
  logic [IDX_W-1:0]  s1_col_q, s1_row_q;
  logic [LUMA_W-1:0] s1_luma_q;
  logic              s1_load_q, s1_emit_q;

  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_col_q;
  logic [SUM_W-1:0]  fwd_sum_q;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic              fwd_hit;
  logic [SUM_W-1:0]  base, sum;

  assign rd_addr = req_i.col[AW-1:0];
  assign wr_addr = s1_col_q[AW-1:0];

  // the write of the previous cycle is not yet in the read data
  assign fwd_hit = fwd_valid_q && (fwd_col_q == wr_addr);

  always_comb begin
    if (s1_load_q) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_sum_q;
    end else if (vld_q[wr_addr]) begin
      base = rdata_q;
    end else begin
      base = '0;
    end
    sum = base + SUM_W'(s1_luma_q);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (s1_valid_q) begin
      mem_q[wr_addr] <= sum;
    end
  end

  // an entry not written since the frame began reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (s1_valid_q) begin
        vld_q[wr_addr] <= 1'b1;
      end
      s1_valid_q  <= req_i.valid;
      fwd_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_col_q  <= req_i.col;
      s1_row_q  <= req_i.row;
      s1_luma_q <= req_i.luma;
      s1_load_q <= req_i.load;
      s1_emit_q <= req_i.emit;
    end
    fwd_col_q <= wr_addr;
    fwd_sum_q <= sum;
  end

  assign div_req_o.valid = s1_valid_q && s1_emit_q;
  assign div_req_o.sum   = sum;
  assign div_req_o.col   = s1_col_q;
  assign div_req_o.row   = s1_row_q;

endmodule

FILE: hw/rtl/clba_div.sv
module clba_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  clba_pkg::clba_div_req_t     req_i,
  input  logic [clba_pkg::PX_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output clba_pkg::clba_out_t         out_data_o
);
  import clba_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  clba_div_state_e   state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q;
  logic [PX_W-1:0]   rem_q, dvs_q;
  logic [IDX_W-1:0]  col_q, row_q;
  logic [PX_W:0]     trial, diff;
  logic              ge;

  // partial remainder stays below the divisor, so one more bit is enough
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      DIV_IDLE: begin
        cnt_d = '0;
        if (req_i.valid) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        if (out_ready_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && req_i.valid) begin
      quo_q <= req_i.sum;
      rem_q <= '0;
      dvs_q <= divisor_i;
      col_q <= req_i.col;
      row_q <= req_i.row;
    end else if (state_q == DIV_RUN) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[PX_W-1:0] : trial[PX_W-1:0];
    end
  end

  assign busy_o               = (state_q != DIV_IDLE);
  assign out_valid_o          = (state_q == DIV_HOLD);
  assign out_data_o.cell_col  = col_q;
  assign out_data_o.cell_row  = row_q;
  assign out_data_o.mean_luma = quo_q[LUMA_W-1:0];

endmodule
